// ===== rtl/core/utf8v_pkg.sv =====
// Shared types, constants and the lead-byte decoding function for the UTF-8 string validator.
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int POS_OUT_W   = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH = 1'd1;

    localparam logic [2:0] REASON_OK         = 3'd0;
    localparam logic [2:0] REASON_TOO_SHORT  = 3'd1;
    localparam logic [2:0] REASON_BAD_LEAD   = 3'd2;
    localparam logic [2:0] REASON_BAD_CONT   = 3'd3;
    localparam logic [2:0] REASON_SEQ_LIMIT  = 3'd4;
    localparam logic [2:0] REASON_CONTROL    = 3'd5;
    localparam logic [2:0] REASON_NO_TERM    = 3'd6;

    localparam logic [7:0] CONT_MASK    = 8'hc0;
    localparam logic [7:0] CONT_PATTERN = 8'h80;
    localparam logic [7:0] LEAD_PATTERN = 8'hc0;
    localparam logic [7:0] LEAD_BITS    = 8'h3f;
    localparam logic [7:0] CONTROL_TOP  = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_LF      = 8'h0a;
    localparam logic [7:0] CHAR_CR      = 8'h0d;

    // Number of continuation bytes announced by a lead byte; zero marks 0xFE and 0xFF.
    function automatic logic [2:0] lead_continuations(input logic [7:0] ch);
        logic [7:0] v;
        v = ch & LEAD_BITS;
        if (v < 8'h20) begin
            return 3'd1;
        end else if (v < 8'h30) begin
            return 3'd2;
        end else if (v < 8'h38) begin
            return 3'd3;
        end else if (v < 8'h3c) begin
            return 3'd4;
        end else if (v < 8'h3e) begin
            return 3'd5;
        end else begin
            return 3'd0;
        end
    endfunction

    typedef struct packed {
        logic       give;
        logic       accepted;
        logic [2:0] reason;
        logic [2:0] cont_next;
        logic       given_next;
    } utf8v_decision_t;

endpackage

// ===== rtl/core/utf8v_check.sv =====
// Per-byte decision logic: examines one byte against the string state and limits.
`timescale 1ns / 1ps

module utf8v_check import utf8v_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic [7:0]             data_byte,
    input  logic                   start_of_string,
    input  logic [LENGTH_BITS-1:0] position,
    input  logic [2:0]             continuations,
    input  logic                   verdict_given,
    input  logic [LENGTH_BITS-1:0] min_length,
    input  logic [LENGTH_BITS-1:0] max_length,
    output logic [LENGTH_BITS-1:0] position_used,
    output logic [LENGTH_BITS-1:0] position_next,
    output utf8v_decision_t        decision
);

    logic [LENGTH_BITS-1:0] eff_pos;
    logic [2:0]             eff_cont;
    logic                   eff_given;
    logic [2:0]             lead_count;
    logic [2:0]             cont_after;
    logic [LENGTH_BITS:0]   pos_plus_lead;
    logic [LENGTH_BITS:0]   pos_plus_one;
    logic [LENGTH_BITS:0]   max_wide;
    logic                   is_control;

    assign eff_pos       = start_of_string ? '0 : position;
    assign eff_cont      = start_of_string ? 3'd0 : continuations;
    assign eff_given     = start_of_string ? 1'b0 : verdict_given;
    assign lead_count    = lead_continuations(data_byte);
    assign pos_plus_lead = {1'b0, eff_pos} + {{(LENGTH_BITS-2){1'b0}}, lead_count};
    assign pos_plus_one  = {1'b0, eff_pos} + {{LENGTH_BITS{1'b0}}, 1'b1};
    assign max_wide      = {1'b0, max_length};
    assign is_control    = (data_byte < CONTROL_TOP)
                        && !(data_byte inside {CHAR_TAB, CHAR_LF, CHAR_CR});
    assign position_used = eff_pos;
    assign position_next = pos_plus_one[LENGTH_BITS-1:0];

    always_comb begin
        decision.give       = 1'b0;
        decision.accepted   = 1'b0;
        decision.reason     = REASON_OK;
        decision.given_next = eff_given;
        cont_after          = eff_cont;

        if (!eff_given) begin
            if (eff_pos >= max_length) begin
                decision.give   = 1'b1;
                decision.reason = REASON_NO_TERM;
            end else if (eff_cont != 3'd0) begin
                if ((data_byte & CONT_MASK) != CONT_PATTERN) begin
                    decision.give   = 1'b1;
                    decision.reason = REASON_BAD_CONT;
                end else begin
                    cont_after = eff_cont - 3'd1;
                end
            end else if (data_byte == 8'h00) begin
                decision.give = 1'b1;
                if (eff_pos >= min_length) begin
                    decision.accepted = 1'b1;
                    decision.reason   = REASON_OK;
                end else begin
                    decision.reason = REASON_TOO_SHORT;
                end
            end else if (data_byte[7]) begin
                if ((data_byte & CONT_MASK) != LEAD_PATTERN || lead_count == 3'd0) begin
                    decision.give   = 1'b1;
                    decision.reason = REASON_BAD_LEAD;
                end else if (pos_plus_lead >= max_wide) begin
                    decision.give   = 1'b1;
                    decision.reason = REASON_SEQ_LIMIT;
                end else begin
                    cont_after = lead_count;
                end
            end else if (is_control) begin
                decision.give   = 1'b1;
                decision.reason = REASON_CONTROL;
            end

            if (!decision.give && cont_after == 3'd0 && pos_plus_one >= max_wide) begin
                decision.give   = 1'b1;
                decision.reason = REASON_NO_TERM;
            end

            if (decision.give) begin
                decision.given_next = 1'b1;
            end
        end

        decision.cont_next = cont_after;
    end

endmodule

// ===== rtl/core/utf8_string_validator.sv =====
// Top level of the UTF-8 string validator: stream ports, registers and pipeline control.
`timescale 1ns / 1ps

// Checks a byte string, one byte per transaction, for legacy UTF-8 of up to six-byte
// sequences ending in a zero terminator within min_length and max_length. At most one
// result transaction is produced per string, at the byte that decides it; bytes after the
// verdict produce nothing until the next start_of_string. One byte is taken every cycle
// while the result side is not stalled; a byte passes through an input register and a
// result register, with the position and continuation state updated between them.
// Back-pressure on the result side stalls the whole pipeline.
module utf8_string_validator import utf8v_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] start_of_string
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // [0] accepted, [3:1] reason,
                                              // [19:4] byte_position, [23:20] zero
);

    localparam logic [31:0] MAX_RESET_WIDE = 32'h0000_ffff;
    localparam logic [LENGTH_BITS-1:0] MAX_RESET = MAX_RESET_WIDE[LENGTH_BITS-1:0];

    logic [LENGTH_BITS-1:0] min_length_reg;
    logic [LENGTH_BITS-1:0] max_length_reg;
    logic [31:0]            cfg_wide;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_start_reg;

    logic [LENGTH_BITS-1:0] position_reg;
    logic [LENGTH_BITS-1:0] position_next;
    logic [2:0]             cont_reg;
    logic                   given_reg;

    logic                   out_valid_reg;
    logic                   out_accepted_reg;
    logic [2:0]             out_reason_reg;
    logic [POS_OUT_W-1:0]   out_pos_reg;

    logic                   advance;
    logic [LENGTH_BITS-1:0] pos_used;
    logic [LENGTH_BITS-1:0] pos_incr;
    logic [31:0]            pos_used_wide;
    utf8v_decision_t        decision;

    assign cfg_wide      = {{(32-CFG_DATA_W){1'b0}}, cfg_wdata};
    assign advance       = !out_valid_reg || m_tready;
    assign s_tready      = !in_valid_reg || advance;
    assign pos_used_wide = 32'(pos_used);

    utf8v_check #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_check (
        .data_byte       (in_byte_reg),
        .start_of_string (in_start_reg),
        .position        (position_reg),
        .continuations   (cont_reg),
        .verdict_given   (given_reg),
        .min_length      (min_length_reg),
        .max_length      (max_length_reg),
        .position_used   (pos_used),
        .position_next   (pos_incr),
        .decision        (decision)
    );

    assign position_next = decision.give ? pos_used
                         : (decision.given_next ? pos_used : pos_incr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_reg <= '0;
            max_length_reg <= MAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_MIN_LENGTH: min_length_reg <= cfg_wide[LENGTH_BITS-1:0];
                REG_MAX_LENGTH: max_length_reg <= cfg_wide[LENGTH_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata[7:0];
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            cont_reg     <= 3'd0;
            given_reg    <= 1'b0;
        end else if (in_valid_reg && advance) begin
            position_reg <= position_next;
            cont_reg     <= decision.cont_next;
            given_reg    <= decision.given_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg && decision.give;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg && decision.give) begin
            out_accepted_reg <= decision.accepted;
            out_reason_reg   <= decision.reason;
            out_pos_reg      <= pos_used_wide[POS_OUT_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-POS_OUT_W-4){1'b0}}, out_pos_reg,
                       out_reason_reg, out_accepted_reg};

    a_accept_means_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == REASON_OK)))
        else $error("Accepted flag disagrees with the reason code.");

    a_reason_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= REASON_NO_TERM))
        else $error("Reason code out of range.");

    a_cont_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cont_reg <= 3'd5)
        else $error("More than five continuation bytes pending.");

    a_silent_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && advance && given_reg && !in_start_reg) |=> !m_tvalid)
        else $error("Result produced after the verdict for this string.");

endmodule
